@@ sv/k80tp_pkg.sv @@
`timescale 1ns / 1ps

package k80tp_pkg;

  // Fraction bits of the probability outputs (unsigned Q(32-F).F).
  localparam int PROB_FRAC_BITS = 31;

  localparam int AGE_W   = 32;
  localparam int PROB_W  = 32;
  localparam int KAPPA_W = 24;
  localparam logic [KAPPA_W-1:0] KAPPA_RESET = 24'h01_0000;

  // Saturated branch length: Q.32 value at most 4096.0.
  localparam int T_W = 45;
  localparam logic [T_W-1:0] T_LIMIT = 45'h1000_0000_0000;

  // Exponent argument width (Q.32, up to 2*4096.0) and quotient width.
  localparam int X_W = 46;
  // Exponential result width (Q.62, at most 1.0).
  localparam int E_W = 63;

  typedef struct packed {
    logic                neg;
    logic [PROB_W-1:0]   p_transversion;
    logic [PROB_W-1:0]   p_transition;
    logic [PROB_W-1:0]   p_same;
  } result_t;

endpackage

@@ sv/k80_transition_probabilities_unit.sv @@
`timescale 1ns / 1ps

// Channel | Dir | tdata (low bit up)                        | tuser
// in_     | in  | start_age, end_age, subst_rate (32 each)  | -
// out_    | out | p_same, p_transition, p_transversion (32) | negative_length
// cfg_    | in  | kappa_ratio (24, unsigned Q8.16)          | -
//
// One item per cycle sustained while no stall fills the skid entry; an item
// passes 122 register stages from the accepting edge to out_tvalid. Depth is
// set by the 47-stage quotient divider and the two 69-stage exponential lanes.
// rst_n clears all valid bits and sets kappa to 1.0; no clearing pass.
// A stall on out_tready freezes the pipeline only once the skid entry is
// full; in_tready then drops until the output register drains.
module k80_transition_probabilities_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [95:0]                   in_tdata,   // start_age, end_age, subst_rate
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [95:0]                   out_tdata,  // p_same, p_transition, p_transversion
  output logic                          out_tuser,  // negative_length
  input  logic                          cfg_wr_en,
  input  logic [k80tp_pkg::KAPPA_W-1:0] cfg_wr_data
);

  localparam int F     = k80tp_pkg::PROB_FRAC_BITS;
  localparam int SHIFT = 62 - F;
  localparam logic [63:0] HALF = 64'h1 << (61 - F);

  logic en;
  logic full;
  logic [k80tp_pkg::KAPPA_W-1:0] kappa_r;

  logic [31:0] start_age, end_age, subst_rate;

  logic        s1_v_r, s1_neg_r;
  logic [31:0] s1_d_r, s1_rate_r;
  logic        s2_v_r, s2_neg_r;
  logic [63:0] s2_t_r;
  logic        s3_v_r, s3_neg_r;
  logic [k80tp_pkg::T_W-1:0] s3_t_r;

  logic        dv, dneg;
  logic [k80tp_pkg::T_W-1:0] dt;
  logic [k80tp_pkg::X_W-1:0] dq;

  logic        s4_v_r, s4_neg_r;
  logic [k80tp_pkg::X_W-1:0] s4_x1_r, s4_x2_r;

  logic        ev, eneg;
  logic [k80tp_pkg::E_W-1:0] ea, eb;

  logic        s5_v_r;
  k80tp_pkg::result_t s5_r, s5_nxt, res;

  assign start_age  = in_tdata[31:0];
  assign end_age    = in_tdata[63:32];
  assign subst_rate = in_tdata[95:64];

  // Advance the whole pipeline unless the skid entry holds an item.
  assign en        = ~full;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kappa_r <= k80tp_pkg::KAPPA_RESET;
    end else if (cfg_wr_en) begin
      kappa_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= dv;
      s5_v_r <= ev;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Clamp a negative branch length to zero and flag it.
      s1_neg_r  <= start_age < end_age;
      s1_d_r    <= (start_age < end_age) ? '0 : start_age - end_age;
      s1_rate_r <= subst_rate;
      s2_neg_r  <= s1_neg_r;
      s2_t_r    <= {32'b0, s1_d_r} * {32'b0, s1_rate_r};
      s3_neg_r  <= s2_neg_r;
      s3_t_r    <= (s2_t_r > 64'(k80tp_pkg::T_LIMIT)) ? k80tp_pkg::T_LIMIT
                                                      : s2_t_r[k80tp_pkg::T_W-1:0];
      s4_neg_r  <= dneg;
      s4_x1_r   <= dq;
      // x2 = 2t - x1/2; never negative since beta is at most 2.
      s4_x2_r   <= {dt, 1'b0} - {1'b0, dq[k80tp_pkg::X_W-1:1]};
      s5_r      <= s5_nxt;
    end
  end

  k80tp_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (s3_v_r),
    .in_tag  (s3_neg_r),
    .in_t    (s3_t_r),
    .kappa   (kappa_r),
    .out_v   (dv),
    .out_tag (dneg),
    .out_t   (dt),
    .out_q   (dq)
  );

  k80tp_exp u_exp (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (s4_v_r),
    .in_tag  (s4_neg_r),
    .in_x1   (s4_x1_r),
    .in_x2   (s4_x2_r),
    .out_v   (ev),
    .out_tag (eneg),
    .out_a   (ea),
    .out_b   (eb)
  );

  // Combine a and b in Q.62, then round half up to the output precision.
  always_comb begin
    logic [63:0] base;
    logic [63:0] half_b;
    logic [63:0] same;
    logic [63:0] trans;
    logic [63:0] tv;
    logic [63:0] rs, rt, rv;
    base   = (64'h1 << 60) + (64'(ea) >> 2);
    half_b = 64'(eb) >> 1;
    same   = base + half_b;
    trans  = (base > half_b) ? base - half_b : '0;  // hold at zero
    tv     = ((64'h1 << 62) - 64'(ea)) >> 2;
    rs     = (same + HALF) >> SHIFT;
    rt     = (trans + HALF) >> SHIFT;
    rv     = (tv + HALF) >> SHIFT;
    s5_nxt.neg            = eneg;
    s5_nxt.p_same         = rs[31:0];
    s5_nxt.p_transition   = rt[31:0];
    s5_nxt.p_transversion = rv[31:0];
  end

  k80tp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s5_v_r),
    .in_item   (s5_r),
    .full      (full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (res)
  );

  assign out_tdata = {res.p_transversion, res.p_transition, res.p_same};
  assign out_tuser = res.neg;

endmodule

@@ sv/k80tp_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage:
// q = floor(t * 2^18 / (kappa + 2^17)).
module k80tp_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_v,
  input  logic                          in_tag,
  input  logic [k80tp_pkg::T_W-1:0]     in_t,
  input  logic [k80tp_pkg::KAPPA_W-1:0] kappa,
  output logic                          out_v,
  output logic                          out_tag,
  output logic [k80tp_pkg::T_W-1:0]     out_t,
  output logic [k80tp_pkg::X_W-1:0]     out_q
);

  localparam int NSTG = k80tp_pkg::X_W;

  typedef struct packed {
    logic                      tag;
    logic [k80tp_pkg::T_W-1:0] t;
    logic [24:0]               rem;
    logic [NSTG-1:0]           w;
  } dstg_t;

  logic [24:0] divisor;
  logic [NSTG:0] v_r;
  dstg_t st_r [NSTG+1];

  assign divisor = 25'(kappa) + 25'h2_0000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  // Load the numerator t << 18: upper 17 bits seed the remainder.
  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0].tag <= in_tag;
      st_r[0].t   <= in_t;
      st_r[0].rem <= {8'b0, in_t[44:28]};
      st_r[0].w   <= {in_t[27:0], 18'b0};
    end
  end

  for (genvar s = 0; s < NSTG; s++) begin : g_step
    dstg_t nxt;
    logic [25:0] trial;

    always_comb begin
      nxt   = st_r[s];
      trial = {st_r[s].rem, st_r[s].w[NSTG-1]};
      if (trial >= {1'b0, divisor}) begin
        nxt.rem = 25'(trial - {1'b0, divisor});
        nxt.w   = {st_r[s].w[NSTG-2:0], 1'b1};
      end else begin
        nxt.rem = trial[24:0];
        nxt.w   = {st_r[s].w[NSTG-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1] <= v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[s+1] <= nxt;
      end
    end
  end

  assign out_v   = v_r[NSTG];
  assign out_tag = st_r[NSTG].tag;
  assign out_t   = st_r[NSTG].t;
  assign out_q   = st_r[NSTG].w;

endmodule

@@ sv/k80tp_exp.sv @@
`timescale 1ns / 1ps

// Two lanes of exp(-x), x in Q.32, result in Q.62. Per lane: Taylor series
// of exp(-x/1024) to order 12, then 10 squarings. Each series term takes
// four stages: a split multiply by x/1024 (partial products, then sum) and a
// split multiply by a scaled reciprocal of the term index, which gives the
// exact floor quotient. Each squaring is a split multiply.
module k80tp_exp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_v,
  input  logic                      in_tag,
  input  logic [k80tp_pkg::X_W-1:0] in_x1,
  input  logic [k80tp_pkg::X_W-1:0] in_x2,
  output logic                      out_v,
  output logic                      out_tag,
  output logic [k80tp_pkg::E_W-1:0] out_a,
  output logic [k80tp_pkg::E_W-1:0] out_b
);

  localparam int TERMS    = 12;
  localparam int HALVINGS = 10;
  localparam int TERM_STG = 4;  // two stages for the product, two for the quotient
  localparam int NSTG     = TERMS * TERM_STG + HALVINGS * 2;
  localparam int EW       = k80tp_pkg::E_W;

  typedef struct packed {
    logic [EW-1:0] term;
    logic [EW-1:0] sum;
    logic [61:0]   r;
    logic          zero;
    logic [63:0]   p00;
    logic [63:0]   p01;
    logic [63:0]   p10;
    logic [63:0]   p11;
  } lane_t;

  typedef struct packed {
    logic          tag;
    lane_t [1:0]   ln;
  } estg_t;

  logic [NSTG:0] v_r;
  estg_t st_r [NSTG+1];
  estg_t init;

  always_comb begin
    init     = '0;
    init.tag = in_tag;
    init.ln[0].zero = |in_x1[45:38];
    init.ln[0].r    = {4'b0, in_x1[37:0], 20'b0};
    init.ln[1].zero = |in_x2[45:38];
    init.ln[1].r    = {4'b0, in_x2[37:0], 20'b0};
    for (int l = 0; l < 2; l++) begin
      init.ln[l].term = 63'h4000_0000_0000_0000;
      init.ln[l].sum  = 63'h4000_0000_0000_0000;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= init;
    end
  end

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    localparam bit TAY  = (s < TERMS * TERM_STG);
    localparam int PH   = s % TERM_STG;
    localparam int KK   = s / TERM_STG + 1;
    localparam int SQPH = s % 2;
    localparam bit MULA = TAY ? ((PH == 0) || (PH == 2)) : (SQPH == 0);
    // floor(v / KK) == floor(v * MK / 2^(63 + LK)) for every v below 2^63.
    localparam int LK   = $clog2(KK);
    localparam int QSH  = 63 + LK;
    localparam logic [63:0] MK = 64'(((128'd1 << QSH) / 128'(KK)) + 128'd1);

    estg_t nxt;

    always_comb begin
      logic [63:0]  ao;
      logic [63:0]  bo;
      logic [127:0] prod;
      logic [127:0] quo;
      nxt = st_r[s];
      for (int l = 0; l < 2; l++) begin
        ao = TAY ? {1'b0, st_r[s].ln[l].term} : {1'b0, st_r[s].ln[l].sum};
        if (!TAY) begin
          bo = {1'b0, st_r[s].ln[l].sum};
        end else if (PH == 0) begin
          bo = {2'b0, st_r[s].ln[l].r};
        end else begin
          bo = MK;
        end
        prod = {st_r[s].ln[l].p11, 64'b0}
             + {32'b0, st_r[s].ln[l].p01, 32'b0}
             + {32'b0, st_r[s].ln[l].p10, 32'b0}
             + {64'b0, st_r[s].ln[l].p00};
        quo  = prod >> QSH;
        nxt.ln[l].p00 = '0;
        nxt.ln[l].p01 = '0;
        nxt.ln[l].p10 = '0;
        nxt.ln[l].p11 = '0;
        if (MULA) begin
          nxt.ln[l].p00 = {32'b0, ao[31:0]} * {32'b0, bo[31:0]};
          nxt.ln[l].p01 = {32'b0, ao[31:0]} * {32'b0, bo[63:32]};
          nxt.ln[l].p10 = {32'b0, ao[63:32]} * {32'b0, bo[31:0]};
          nxt.ln[l].p11 = {32'b0, ao[63:32]} * {32'b0, bo[63:32]};
        end else if (!TAY) begin
          nxt.ln[l].sum = prod[124:62];
        end else if (PH == 1) begin
          nxt.ln[l].term = prod[124:62];
        end else begin
          // Quotient by the term index, then fold the term into the sum.
          nxt.ln[l].term = quo[EW-1:0];
          if (KK % 2 == 1) begin
            nxt.ln[l].sum = st_r[s].ln[l].sum - quo[EW-1:0];
          end else begin
            nxt.ln[l].sum = st_r[s].ln[l].sum + quo[EW-1:0];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1] <= v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[s+1] <= nxt;
      end
    end
  end

  // Arguments of 64.0 and above give zero.
  assign out_v   = v_r[NSTG];
  assign out_tag = st_r[NSTG].tag;
  assign out_a   = st_r[NSTG].ln[0].zero ? '0 : st_r[NSTG].ln[0].sum;
  assign out_b   = st_r[NSTG].ln[1].zero ? '0 : st_r[NSTG].ln[1].sum;

endmodule

@@ sv/k80tp_outq.sv @@
`timescale 1ns / 1ps

// Output register plus one skid entry.
module k80tp_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  k80tp_pkg::result_t in_item,
  output logic               full,
  output logic               out_valid,
  input  logic               out_ready,
  output k80tp_pkg::result_t out_item
);

  logic out_v_r;
  logic skid_v_r;
  k80tp_pkg::result_t out_r;
  k80tp_pkg::result_t skid_r;
  logic take_out;
  logic take_in;

  assign take_out = out_v_r & out_ready;
  assign take_in  = in_valid & ~skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (take_out) begin
        skid_v_r <= 1'b0;
      end
    end else if (take_in) begin
      if (!out_v_r || take_out) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (take_out) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r && take_out) begin
      out_r <= skid_r;
    end else if (take_in && (!out_v_r || take_out)) begin
      out_r <= in_item;
    end
    if (take_in && out_v_r && !take_out) begin
      skid_r <= in_item;
    end
  end

  assign full      = skid_v_r;
  assign out_valid = out_v_r;
  assign out_item  = out_r;

endmodule

@@ sv/k80tp_checker.sv @@
`timescale 1ns / 1ps

module k80tp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic        out_tuser
);

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Input back-pressure only while a result waits.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

  a_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[31:0] == (32'h1 << k80tp_pkg::PROB_FRAC_BITS) &&
      out_tdata[63:32] == 32'h0 && out_tdata[95:64] == 32'h0)
    else $error("clamped branch gives wrong matrix");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31:0] >= out_tdata[63:32] &&
      out_tdata[95:64] <= (32'h1 << (k80tp_pkg::PROB_FRAC_BITS - 2)))
    else $error("probability out of range");

endmodule

bind k80_transition_probabilities_unit k80tp_checker u_k80tp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
